[rtl/hicm_pkg.sv]
// Shared types and constants for the header ID compression map.
// Used by the datapath, the controller and the top level; depends on nothing.

package hicm_pkg;

    // Table geometry
    localparam int ID_SPACE = 256;
    localparam int SLOT_W   = $clog2(ID_SPACE);
    localparam int COUNT_W  = SLOT_W + 1;
    localparam int RID_W    = 16;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(ID_SPACE - 1);

    // Stream word widths
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 40;
    localparam int USER_W   = 2;

    // Operation codes
    typedef enum logic [1:0] {
        FUNC_COMPRESS   = 2'd0,
        FUNC_DECOMPRESS = 2'd1,
        FUNC_REMOVE     = 2'd2,
        FUNC_NONE       = 2'd3
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_FOUND     = 2'd0,
        STATUS_ASSIGNED  = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_DRAIN,
        S_RESP
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic scan_issue;
        logic rd_cid;
        logic commit;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        func_t in_func;
        func_t func;
        logic  scan_last;
        logic  out_busy;
    } sts_t;

endpackage

[rtl/hicm_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module hicm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/hicm_dp.sv]
// Datapath of the header ID compression map: input capture, slot valid bits,
// real ID store (hicm_ram), scan compare, slot choice and result register.
// Depends on hicm_pkg and hicm_ram.

module hicm_dp
    import hicm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output sts_t                sts,
    input  logic [USER_W-1:0]   in_user,
    input  logic [S_DATA_W-1:0] in_data,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [SLOT_W-1:0]   out_comp_id,
    output logic [RID_W-1:0]    out_real_id,
    output logic [USER_W-1:0]   out_status,
    output logic [COUNT_W-1:0]  out_used_count
);

    // Captured input word
    func_t              func_reg;
    logic [RID_W-1:0]   rid_reg;
    logic [SLOT_W-1:0]  cid_reg;

    // Table state
    logic [ID_SPACE-1:0] valid_reg, valid_next;
    logic [COUNT_W-1:0]  count_reg, count_next;

    // Scan state
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [SLOT_W-1:0] idx_d_reg;
    logic              cmp_v_reg;
    logic              match_found_reg, match_found_next;
    logic [SLOT_W-1:0] match_idx_reg, match_idx_next;
    logic              above_found_reg, above_found_next;
    logic [SLOT_W-1:0] above_idx_reg, above_idx_next;
    logic              below_found_reg, below_found_next;
    logic [SLOT_W-1:0] below_idx_reg, below_idx_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0] out_cid_reg;
    logic [RID_W-1:0]  out_rid_reg;
    status_t           out_st_reg;
    logic [COUNT_W-1:0] out_used_reg;

    // RAM ports
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [SLOT_W-1:0] ram_raddr;
    logic [RID_W-1:0]  ram_rdata;

    // Result of the current operation
    logic [SLOT_W-1:0] hi_slot, lo_slot, free_slot;
    logic [SLOT_W-1:0] res_cid;
    logic [RID_W-1:0]  res_rid;
    status_t           res_st;
    logic              hit, free;

    hicm_ram #(
        .WIDTH (RID_W),
        .DEPTH (ID_SPACE)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (rid_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_raddr = cmd.rd_cid ? cid_reg : idx_reg;
    assign hi_slot   = rid_reg[RID_W-1 -: SLOT_W];
    assign lo_slot   = rid_reg[SLOT_W-1:0];

    // Compare stage: one slot a cycle, read data lines up with idx_d_reg
    assign hit  = cmp_v_reg && valid_reg[idx_d_reg] && (ram_rdata == rid_reg);
    assign free = cmp_v_reg && !valid_reg[idx_d_reg];

    // Track the match and the first free slot above and at/below the high byte
    always_comb
    begin
        idx_next         = idx_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        above_found_next = above_found_reg;
        above_idx_next   = above_idx_reg;
        below_found_next = below_found_reg;
        below_idx_next   = below_idx_reg;
        if (cmd.load_in)
        begin
            idx_next         = '0;
            match_found_next = 1'b0;
            above_found_next = 1'b0;
            below_found_next = 1'b0;
        end
        else
        begin
            if (cmd.scan_issue)
            begin
                idx_next = idx_reg + 1'b1;
            end
            if (hit && !match_found_reg)
            begin
                match_found_next = 1'b1;
                match_idx_next   = idx_d_reg;
            end
            if (free && (idx_d_reg > hi_slot) && !above_found_reg)
            begin
                above_found_next = 1'b1;
                above_idx_next   = idx_d_reg;
            end
            if (free && (idx_d_reg <= hi_slot) && !below_found_reg)
            begin
                below_found_next = 1'b1;
                below_idx_next   = idx_d_reg;
            end
        end
    end

    // Choose a slot for a new mapping: high byte, low byte, then wrap search
    always_comb
    begin
        if (!valid_reg[hi_slot])
        begin
            free_slot = hi_slot;
        end
        else if (!valid_reg[lo_slot])
        begin
            free_slot = lo_slot;
        end
        else if (above_found_reg)
        begin
            free_slot = above_idx_reg;
        end
        else
        begin
            free_slot = below_idx_reg;
        end
    end

    // Work out the result and the table update
    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        ram_we     = 1'b0;
        ram_waddr  = free_slot;
        res_cid    = '0;
        res_rid    = '0;
        res_st     = STATUS_NOT_FOUND;
        case (func_reg)
            FUNC_COMPRESS:
            begin
                if (match_found_reg)
                begin
                    res_cid = match_idx_reg;
                    res_st  = STATUS_FOUND;
                end
                else if (!count_reg[SLOT_W])
                begin
                    res_cid = free_slot;
                    res_st  = STATUS_ASSIGNED;
                    if (cmd.commit)
                    begin
                        valid_next[free_slot] = 1'b1;
                        count_next            = count_reg + 1'b1;
                        ram_we                = 1'b1;
                    end
                end
                else
                begin
                    res_st = STATUS_FULL;
                end
            end
            FUNC_DECOMPRESS:
            begin
                if (valid_reg[cid_reg])
                begin
                    res_rid = ram_rdata;
                    res_st  = STATUS_FOUND;
                end
            end
            FUNC_REMOVE:
            begin
                if (match_found_reg)
                begin
                    res_st = STATUS_FOUND;
                    if (cmd.commit)
                    begin
                        valid_next[match_idx_reg] = 1'b0;
                        count_next                = count_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                res_st = STATUS_NOT_FOUND;
            end
        endcase
    end

    // Hold the result word until it is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            count_reg       <= '0;
            idx_reg         <= '0;
            cmp_v_reg       <= 1'b0;
            match_found_reg <= 1'b0;
            above_found_reg <= 1'b0;
            below_found_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            valid_reg       <= valid_next;
            count_reg       <= count_next;
            idx_reg         <= idx_next;
            cmp_v_reg       <= cmd.scan_issue;
            match_found_reg <= match_found_next;
            above_found_reg <= above_found_next;
            below_found_reg <= below_found_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg <= func_t'(in_user);
            rid_reg  <= in_data[RID_W-1:0];
            cid_reg  <= in_data[RID_W +: SLOT_W];
        end
        idx_d_reg     <= idx_reg;
        match_idx_reg <= match_idx_next;
        above_idx_reg <= above_idx_next;
        below_idx_reg <= below_idx_next;
        if (cmd.commit)
        begin
            out_cid_reg  <= res_cid;
            out_rid_reg  <= res_rid;
            out_st_reg   <= res_st;
            out_used_reg <= count_next;
        end
    end

    assign sts.in_func   = func_t'(in_user);
    assign sts.func      = func_reg;
    assign sts.scan_last = (idx_reg == SLOT_LAST);
    assign sts.out_busy  = out_valid_reg && !out_ready;

    assign out_valid      = out_valid_reg;
    assign out_comp_id    = out_cid_reg;
    assign out_real_id    = out_rid_reg;
    assign out_status     = out_st_reg;
    assign out_used_count = out_used_reg;

endmodule

[rtl/hicm_ctrl.sv]
// Controller of the header ID compression map: sequences capture, store read,
// full-table scan and result commit. Depends on hicm_pkg.

module hicm_ctrl
    import hicm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (sts.in_func) inside
                        FUNC_COMPRESS, FUNC_REMOVE: state_next = S_SCAN;
                        FUNC_DECOMPRESS:            state_next = S_READ;
                        default:                    state_next = S_RESP;
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_RESP;
            end
            S_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!sts.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            S_READ:
            begin
                cmd.rd_cid = 1'b1;
            end
            S_SCAN:
            begin
                cmd.scan_issue = 1'b1;
            end
            S_DRAIN:
            begin
                cmd.scan_issue = 1'b0;
            end
            S_RESP:
            begin
                // Keep the store addressed by the short ID while the word waits
                cmd.rd_cid = (sts.func == FUNC_DECOMPRESS);
                cmd.commit = !sts.out_busy;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/header_id_compression_map.sv]
// Header ID compression map: 16-bit real IDs to unique 8-bit compressed IDs.
// Compress and remove each run a full scan of the 256-entry ID store, one slot a
// cycle; decompress reads the store at the short ID; an unknown op goes straight to the result.
// One word in flight: the next word is taken the cycle after the result is loaded.
// Reset clears all slot valid bits and the entry count at once; no clearing pass.
// Depends on hicm_pkg, hicm_ctrl, hicm_dp and hicm_ram.

module header_id_compression_map
    import hicm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,  // real_id[15:0], comp_id[23:16]
    input  logic [USER_W-1:0]   s_axis_tuser,  // func[1:0]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,  // out_comp_id[7:0], out_real_id[23:8],
                                               // used_count[32:24], zero[39:33]
    output logic [USER_W-1:0]   m_axis_tuser   // status[1:0]
);

    cmd_t cmd;
    sts_t sts;

    logic [SLOT_W-1:0]  out_comp_id;
    logic [RID_W-1:0]   out_real_id;
    logic [COUNT_W-1:0] used_count;

    hicm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hicm_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .in_user        (s_axis_tuser),
        .in_data        (s_axis_tdata),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .out_comp_id    (out_comp_id),
        .out_real_id    (out_real_id),
        .out_status     (m_axis_tuser),
        .out_used_count (used_count)
    );

    // Pack the result word
    assign m_axis_tdata = {(M_DATA_W - COUNT_W - RID_W - SLOT_W)'(0),
                           used_count, out_real_id, out_comp_id};

endmodule

[verif/header_id_compression_map_checker.sv]
// Scoreboard for the header ID compression map: tracks the ID table from the words
// accepted on the input stream and checks every result word, field by field.
// Depends on hicm_pkg for the table sizes, operation codes and status codes.
`timescale 1ns / 100ps

module header_id_compression_map_checker
    import hicm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,   // real_id[15:0], comp_id[23:16]
    input  logic [USER_W-1:0]   s_axis_tuser,   // func[1:0]
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [M_DATA_W-1:0] m_axis_tdata,   // out_comp_id[7:0], out_real_id[23:8],
                                                // used_count[32:24], zero[39:33]
    input  logic [USER_W-1:0]   m_axis_tuser,   // status[1:0]
    output int                  fail_count,
    output int                  pending
);

    typedef struct packed {
        logic [SLOT_W-1:0]  comp_id;
        logic [RID_W-1:0]   real_id;
        status_t            status;
        logic [COUNT_W-1:0] used;
    } map_result_t;

    // Shadow copy of the ID table
    bit                 slot_used [ID_SPACE];
    logic [RID_W-1:0]   slot_rid  [ID_SPACE];
    logic [COUNT_W-1:0] used_n = '0;

    map_result_t results_due [$];
    int          errs = 0;
    int          due_n = 0;

    assign fail_count = errs;
    assign pending    = due_n;

    // Slot holding a real ID, or -1 when none does
    function automatic int slot_of(logic [RID_W-1:0] rid);
        int i;
        for (i = 0; i < ID_SPACE; i++)
        begin
            if (slot_used[i] && slot_rid[i] == rid)
                return i;
        end
        return -1;
    endfunction

    // High byte, then low byte, then the first free slot after the high byte, wrapping past the top
    function automatic logic [SLOT_W-1:0] free_slot(logic [RID_W-1:0] rid);
        logic [SLOT_W-1:0] s;
        int                n;
        if (!slot_used[rid[15:8]])
            return rid[15:8];
        if (!slot_used[rid[7:0]])
            return rid[7:0];
        s = rid[15:8];
        for (n = 0; n < ID_SPACE; n++)
        begin
            s = s + 1'b1;
            if (!slot_used[s])
                return s;
        end
        return rid[15:8];
    endfunction

    // Apply one operation to the shadow table and give the result word it causes
    function automatic map_result_t apply_op(func_t op, logic [RID_W-1:0] rid,
                                             logic [SLOT_W-1:0] cid);
        map_result_t       r;
        int                hit;
        logic [SLOT_W-1:0] s;
        r        = '0;
        r.status = STATUS_NOT_FOUND;
        case (op)
            FUNC_COMPRESS:
            begin
                hit = slot_of(rid);
                if (hit >= 0)
                begin
                    r.comp_id = hit[SLOT_W-1:0];
                    r.status  = STATUS_FOUND;
                end
                else if (used_n < ID_SPACE)
                begin
                    s            = free_slot(rid);
                    slot_used[s] = 1'b1;
                    slot_rid[s]  = rid;
                    used_n       = used_n + 1'b1;
                    r.comp_id    = s;
                    r.status     = STATUS_ASSIGNED;
                end
                else
                    r.status = STATUS_FULL;
            end
            FUNC_DECOMPRESS:
            begin
                if (slot_used[cid])
                begin
                    r.real_id = slot_rid[cid];
                    r.status  = STATUS_FOUND;
                end
            end
            FUNC_REMOVE:
            begin
                hit = slot_of(rid);
                if (hit >= 0)
                begin
                    slot_used[hit] = 1'b0;
                    used_n         = used_n - 1'b1;
                    r.status       = STATUS_FOUND;
                end
            end
            default: ;
        endcase
        r.used = used_n;
        return r;
    endfunction

    // Count a failure; show the first few in full
    task automatic flag_result(string what, map_result_t want, map_result_t got,
                               logic [M_DATA_W-1:33] pad);
        errs++;
        if (errs <= 10)
            $display("%0t: %s: expected comp=%h real=%h status=%0d used=%0d, got comp=%h real=%h status=%0d used=%0d pad=%h",
                     $realtime, what, want.comp_id, want.real_id, want.status, want.used,
                     got.comp_id, got.real_id, got.status, got.used, pad);
    endtask

    // Compare result words first, then record the prediction for a new input word
    always @(posedge clk)
    begin
        map_result_t want;
        map_result_t got;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.comp_id = m_axis_tdata[7:0];
                got.real_id = m_axis_tdata[23:8];
                got.used    = m_axis_tdata[32:24];
                got.status  = status_t'(m_axis_tuser);
                if (results_due.size() == 0)
                    flag_result("result word with none due", '0, got, m_axis_tdata[39:33]);
                else
                begin
                    want = results_due.pop_front();
                    if (want.comp_id !== got.comp_id || want.real_id !== got.real_id ||
                        want.status !== got.status || want.used !== got.used ||
                        m_axis_tdata[39:33] !== '0)
                        flag_result("result word mismatch", want, got, m_axis_tdata[39:33]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                results_due.push_back(apply_op(func_t'(s_axis_tuser), s_axis_tdata[15:0],
                                               s_axis_tdata[23:16]));
        end
        due_n = results_due.size();
    end

endmodule

[verif/header_id_compression_map_tb.sv]
// Testbench top for the header ID compression map: drives operation words with random
// gaps and output stalls, and gives the verdict from the checker's failure and pending counts.
// Depends on hicm_pkg, header_id_compression_map and header_id_compression_map_checker.
`timescale 1ns / 100ps

module header_id_compression_map_tb;
    import hicm_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;   // real_id[15:0], comp_id[23:16]
    logic [USER_W-1:0]   s_axis_tuser;   // func[1:0]
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;   // out_comp_id[7:0], out_real_id[23:8],
                                         // used_count[32:24], zero[39:33]
    logic [USER_W-1:0]   m_axis_tuser;   // status[1:0]

    int fail_count;
    int pending;
    int sent_n = 0;

    // Slots that have held a real ID at some point; only these are decompressed
    bit               slot_seen [ID_SPACE];
    logic [RID_W-1:0] id_pool   [48];
    logic [RID_W-1:0] held_ids  [$];

    header_id_compression_map u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    header_id_compression_map_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always #1 clk = ~clk;

    // Note slots handed out, so decompress never reads a slot never written
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready && m_axis_tuser == STATUS_ASSIGNED)
            slot_seen[m_axis_tdata[7:0]] <= 1'b1;
    end

    // One stretch in four runs with no gaps and no stalls
    function automatic bit quiet_stretch();
        return ((sent_n >> 6) % 4) == 3;
    endfunction

    // A slot that has been written, from a random start, or -1 when there is none
    function automatic int written_slot();
        int start;
        int i;
        start = $urandom_range(0, ID_SPACE - 1);
        for (i = 0; i < ID_SPACE; i++)
        begin
            if (slot_seen[(start + i) % ID_SPACE])
                return (start + i) % ID_SPACE;
        end
        return -1;
    endfunction

    // Present one word after a random gap and hold it until taken
    task automatic send_word(func_t op, logic [RID_W-1:0] rid, logic [SLOT_W-1:0] cid);
        int gap;
        gap = quiet_stretch() ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cid, rid};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent_n++;
    endtask

    // Mixed operation on a given real ID; unused fields carry noise
    task automatic random_op(logic [RID_W-1:0] rid);
        int r;
        int c;
        r = $urandom_range(0, 99);
        c = written_slot();
        if (r < 45)
            send_word(FUNC_COMPRESS, rid, SLOT_W'($urandom));
        else if (r < 70 && c >= 0)
            send_word(FUNC_DECOMPRESS, RID_W'($urandom), SLOT_W'(c));
        else if (r < 95)
            send_word(FUNC_REMOVE, rid, SLOT_W'($urandom));
        else
            send_word(FUNC_NONE, RID_W'($urandom), SLOT_W'($urandom));
    endtask

    // Output side: stall a random number of cycles per word, at times only once
    // the word is waiting
    initial
    begin
        int stall;
        bit on_valid;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall    = quiet_stretch() ? 0 : $urandom_range(0, 4);
            on_valid = $urandom_range(0, 1);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                if (on_valid)
                begin
                    @(posedge clk);
                    while (!m_axis_tvalid)
                        @(posedge clk);
                end
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    // Stimulus and verdict
    initial
    begin
        logic [7:0]       hb [6];
        logic [7:0]       lb [8];
        logic [RID_W-1:0] rid;
        logic [RID_W-1:0] base;
        int               i;
        int               r;
        int               c;
        int               idx;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= FUNC_COMPRESS;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, slot choice fallbacks, wrap, extremes, misses
        send_word(FUNC_REMOVE,     16'h1234, 8'h00);
        send_word(FUNC_NONE,       16'hFFFF, 8'hFF);
        send_word(FUNC_COMPRESS,   16'h0000, 8'h00);
        send_word(FUNC_COMPRESS,   16'h0000, 8'hFF);
        send_word(FUNC_COMPRESS,   16'hFFFF, 8'h00);
        send_word(FUNC_COMPRESS,   16'h00FF, 8'h00);
        send_word(FUNC_COMPRESS,   16'h0100, 8'h00);
        send_word(FUNC_COMPRESS,   16'hFF00, 8'h00);
        send_word(FUNC_COMPRESS,   16'h0203, 8'h00);
        send_word(FUNC_COMPRESS,   16'h0507, 8'h00);
        send_word(FUNC_COMPRESS,   16'h0506, 8'h00);
        send_word(FUNC_DECOMPRESS, 16'hFFFF, 8'h00);
        send_word(FUNC_DECOMPRESS, 16'h0000, 8'hFF);
        send_word(FUNC_DECOMPRESS, 16'h0000, 8'h03);
        send_word(FUNC_REMOVE,     16'hFFFF, 8'h00);
        send_word(FUNC_REMOVE,     16'hFFFF, 8'hFF);
        send_word(FUNC_DECOMPRESS, 16'h0000, 8'hFF);
        send_word(FUNC_COMPRESS,   16'h1234, 8'h00);
        send_word(FUNC_REMOVE,     16'h0000, 8'h00);
        send_word(FUNC_REMOVE,     16'hABCD, 8'h00);
        send_word(FUNC_COMPRESS,   16'hFF00, 8'h00);
        send_word(FUNC_NONE,       16'h5A5A, 8'hA5);
        send_word(FUNC_COMPRESS,   16'h0000, 8'h00);

        // Pool of IDs sharing high and low bytes, so slots collide often
        foreach (hb[k])
            hb[k] = 8'($urandom);
        foreach (lb[k])
            lb[k] = 8'($urandom);
        foreach (id_pool[k])
            id_pool[k] = {hb[$urandom_range(0, 5)], lb[$urandom_range(0, 7)]};

        // Mixed traffic on the pool with some stray IDs
        for (i = 0; i < 550; i++)
        begin
            rid = ($urandom_range(0, 9) == 0) ? RID_W'($urandom) : id_pool[$urandom_range(0, 47)];
            random_op(rid);
        end

        // Fill the table past full with distinct IDs
        base = RID_W'($urandom);
        for (i = 0; i < 330; i++)
        begin
            rid = base + RID_W'(i * 259);
            held_ids.push_back(rid);
            send_word(FUNC_COMPRESS, rid, SLOT_W'($urandom));
        end

        // Churn near full: free slots and refill them through the search
        for (i = 0; i < 300; i++)
        begin
            r   = $urandom_range(0, 99);
            idx = $urandom_range(0, held_ids.size() - 1);
            if (r < 35)
                send_word(FUNC_REMOVE, held_ids[idx], SLOT_W'($urandom));
            else if (r < 60)
                send_word(FUNC_COMPRESS, held_ids[idx], SLOT_W'($urandom));
            else if (r < 85)
            begin
                rid = RID_W'($urandom);
                held_ids.push_back(rid);
                send_word(FUNC_COMPRESS, rid, SLOT_W'($urandom));
            end
            else
            begin
                c = written_slot();
                send_word(FUNC_DECOMPRESS, RID_W'($urandom), SLOT_W'(c));
            end
        end

        // Drain: remove everything held, in random order
        foreach (id_pool[k])
            held_ids.push_back(id_pool[k]);
        while (held_ids.size() > 0)
        begin
            c = written_slot();
            if ($urandom_range(0, 9) == 0 && c >= 0)
                send_word(FUNC_DECOMPRESS, RID_W'($urandom), SLOT_W'(c));
            else
            begin
                idx = $urandom_range(0, held_ids.size() - 1);
                send_word(FUNC_REMOVE, held_ids[idx], SLOT_W'($urandom));
                held_ids.delete(idx);
            end
        end

        // Mixed traffic on a mostly empty table
        while (sent_n < 1875)
        begin
            rid = ($urandom_range(0, 3) == 0) ? RID_W'($urandom) : id_pool[$urandom_range(0, 47)];
            random_op(rid);
        end
        s_axis_tvalid <= 1'b0;

        // Wait for the last results, then a full scan's worth of cycles
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
